// ===== design/mrtu_pkg.sv =====
// Shared types, codes and helper functions for the Modbus RTU reply receiver.
package mrtu_pkg;

  // Item modes.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Completion status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_FN  = 3'd1;
  localparam logic [2:0] ST_EXCEPT  = 3'd2;
  localparam logic [2:0] ST_BAD_CRC = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE    = 2'd0;
  localparam logic [1:0] CFG_FUNCTION = 2'd1;
  localparam logic [1:0] CFG_HEADER   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

  // Function codes that fix the frame length.
  localparam logic [7:0] FN_READ_COILS      = 8'd1;
  localparam logic [7:0] FN_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FN_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FN_READ_INPUT      = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FN_WRITE_REG       = 8'd6;
  localparam logic [7:0] FN_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FN_WRITE_REGS      = 8'd16;
  localparam logic [7:0] FN_MASK_WRITE      = 8'd22;
  localparam logic [7:0] FN_READ_WRITE_REGS = 8'd23;

  localparam logic [8:0] READ_OVERHEAD = 9'd5;
  localparam logic [8:0] WRITE_LENGTH  = 9'd8;
  localparam logic [8:0] MASK_LENGTH   = 9'd10;
  localparam logic [3:0] MIN_HEADER    = 4'd3;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT,
    PH_HEAD,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [7:0]  expected_slave;
    logic [6:0]  expected_function;
    logic [3:0]  header_bytes;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [8:0] frame_length;
  } result_t;

  // Header length with the lower bound of three bytes applied.
  function automatic logic [3:0] header_eff(input logic [3:0] hb);
    return (hb < MIN_HEADER) ? MIN_HEADER : hb;
  endfunction

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Frame length implied by the function code and the byte count.
  function automatic logic [8:0] length_for(input logic [7:0] fn, input logic [7:0] count,
                                            input logic [3:0] hb);
    logic [8:0] len;
    case (fn)
      FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT,
      FN_READ_WRITE_REGS: len = READ_OVERHEAD + {1'b0, count};
      FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS: len = WRITE_LENGTH;
      FN_MASK_WRITE: len = MASK_LENGTH;
      default: len = {5'd0, header_eff(hb)};
    endcase
    return len;
  endfunction

  // Frame bytes actually echoed: bytes past a known length do not count.
  function automatic logic [8:0] echoed(input logic [8:0] seen, input logic [8:0] target);
    return (target != 9'd0 && seen > target) ? target : seen;
  endfunction

endpackage

// ===== design/mrtu_if.sv =====
// Valid/ready channel interfaces for receiver items and results.
interface mrtu_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface mrtu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       byte_valid;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] exception_code;
  logic [8:0] frame_length;

  modport source (output valid, output frame_byte, output byte_valid, output done_res,
                  output status, output exception_code, output frame_length, input ready);
  modport sink (input valid, input frame_byte, input byte_valid, input done_res,
                input status, input exception_code, input frame_length, output ready);
endinterface

// ===== design/mrtu_engine.sv =====
// Frame tracking state, CRC accumulation and completion decisions.
module mrtu_engine import mrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] mode,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [8:0]  bytes_seen, bytes_seen_next;
  logic [8:0]  target_length, target_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [7:0]  third_byte, third_byte_next;
  logic [31:0] tick_count, tick_count_next;

  logic        take;
  logic        check_body;
  logic [3:0]  heff;

  assign heff = header_eff(cfg.header_bytes);

  // Next state and result for the item held in the input register.
  always_comb begin
    phase_next         = phase;
    bytes_seen_next    = bytes_seen;
    target_length_next = target_length;
    running_crc_next   = running_crc;
    second_byte_next   = second_byte;
    third_byte_next    = third_byte;
    tick_count_next    = tick_count;
    res                = '0;
    take               = 1'b0;
    check_body         = 1'b0;

    case (mode)
      MODE_START: begin
        if (phase == PH_IDLE) begin
          phase_next         = PH_HUNT;
          bytes_seen_next    = 9'd0;
          target_length_next = 9'd0;
          running_crc_next   = CRC_INIT;
          second_byte_next   = 8'd0;
          third_byte_next    = 8'd0;
          tick_count_next    = 32'd0;
        end
      end
      MODE_TICK: begin
        if (phase != PH_IDLE) begin
          tick_count_next = tick_count + 32'd1;
          if (tick_count_next >= cfg.timeout_ticks) begin
            res.done_res     = 1'b1;
            res.status       = ST_TIMEOUT;
            res.frame_length = echoed(bytes_seen, target_length);
            phase_next       = PH_IDLE;
          end
        end
      end
      MODE_BYTE: begin
        if (phase == PH_HUNT) begin
          // The slave address opens the frame.
          if (rx_byte == cfg.expected_slave) begin
            running_crc_next = crc_byte(running_crc, rx_byte);
            bytes_seen_next  = 9'd1;
            phase_next       = PH_HEAD;
            res.frame_byte   = rx_byte;
            res.byte_valid   = 1'b1;
          end
        end else if (phase == PH_HEAD || phase == PH_BODY) begin
          take = (bytes_seen < 9'd3) || (bytes_seen < target_length);
          if (take) begin
            running_crc_next = crc_byte(running_crc, rx_byte);
            res.frame_byte   = rx_byte;
            res.byte_valid   = 1'b1;
            if (bytes_seen == 9'd1) begin
              second_byte_next = rx_byte;
            end
            if (bytes_seen == 9'd2) begin
              third_byte_next    = rx_byte;
              target_length_next = length_for(second_byte, rx_byte, cfg.header_bytes);
            end
          end
          bytes_seen_next = bytes_seen + 9'd1;
          check_body      = (phase == PH_BODY);

          // Header check once enough bytes are gathered.
          if (phase == PH_HEAD && bytes_seen_next >= {5'd0, heff}) begin
            if (second_byte_next[7]) begin
              res.done_res       = 1'b1;
              res.status         = ST_EXCEPT;
              res.exception_code = third_byte_next;
              res.frame_length   = echoed(bytes_seen_next, target_length_next);
              phase_next         = PH_IDLE;
            end else if (second_byte_next[6:0] != cfg.expected_function) begin
              res.done_res     = 1'b1;
              res.status       = ST_BAD_FN;
              res.frame_length = echoed(bytes_seen_next, target_length_next);
              phase_next       = PH_IDLE;
            end else begin
              phase_next = PH_BODY;
              check_body = 1'b1;
            end
          end

          // Frame end: the CRC over the whole frame must come to zero.
          if (check_body && bytes_seen_next >= target_length_next) begin
            res.done_res     = 1'b1;
            res.status       = (running_crc_next == 16'd0) ? ST_OK : ST_BAD_CRC;
            res.frame_length = target_length_next;
            phase_next       = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    res_valid = res.byte_valid | res.done_res;
  end

  // State registers advance only when the held item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bytes_seen    <= 9'd0;
      target_length <= 9'd0;
      running_crc   <= CRC_INIT;
      second_byte   <= 8'd0;
      third_byte    <= 8'd0;
      tick_count    <= 32'd0;
    end else if (step) begin
      phase         <= phase_next;
      bytes_seen    <= bytes_seen_next;
      target_length <= target_length_next;
      running_crc   <= running_crc_next;
      second_byte   <= second_byte_next;
      third_byte    <= third_byte_next;
      tick_count    <= tick_count_next;
    end
  end

  // An idle receiver ignores bytes and ticks.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_IDLE && mode != MODE_START) |-> !res_valid)
    else $error("idle receiver produced a result");

  // The body phase always has bytes still to come.
  a_body_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_seen < target_length))
    else $error("body phase with no bytes outstanding");

endmodule

// ===== design/modbus_rtu_response_receiver_core.sv =====
// Top level of the Modbus RTU reply receiver.
// A result is valid on the output once its item has passed the input register and the output register.
// Throughput: one item per cycle while the result side is ready; otherwise items wait in the registers.
// Reset clears the configuration to its defaults and the receiver to idle with no result held.
// Items that cause no result (start, ignored bytes and ticks) leave the output untouched.
module modbus_rtu_response_receiver_core import mrtu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  mrtu_item_if.sink     item,
  mrtu_result_if.source result
);

  cfg_t       cfg;
  logic       in_valid;
  logic [1:0] in_mode;
  logic [7:0] in_byte;
  logic       advance;
  logic       eng_valid;
  result_t    eng_res;
  logic       out_valid;
  result_t    out_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_slave    <= 8'd1;
      cfg.expected_function <= 7'd3;
      cfg.header_bytes      <= 4'd5;
      cfg.timeout_ticks     <= 32'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE:    cfg.expected_slave    <= cfg_data[7:0];
        CFG_FUNCTION: cfg.expected_function <= cfg_data[6:0];
        CFG_HEADER:   cfg.header_bytes      <= cfg_data[3:0];
        CFG_TIMEOUT:  cfg.timeout_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The held item moves on when the output register is free or being emptied.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_mode <= item.mode;
      in_byte <= item.rx_byte;
    end
  end

  mrtu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .mode      (in_mode),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= eng_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eng_valid) begin
      out_res <= eng_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.frame_byte     = out_res.frame_byte;
  assign result.byte_valid     = out_res.byte_valid;
  assign result.done_res       = out_res.done_res;
  assign result.status         = out_res.status;
  assign result.exception_code = out_res.exception_code;
  assign result.frame_length   = out_res.frame_length;

  // A timeout never carries a frame byte.
  a_timeout_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_res && out_res.status == ST_TIMEOUT) |-> !out_res.byte_valid)
    else $error("timeout transaction carries a frame byte");

  // A nonzero exception code only comes with an exception status.
  a_exc_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.exception_code != 8'd0)
      |-> (out_res.done_res && out_res.status == ST_EXCEPT))
    else $error("exception code without exception status");

  // Reported frame length stays within the longest read reply, a byte count of 255 plus five.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done_res) |-> (out_res.frame_length <= 9'd260))
    else $error("frame length out of range");

endmodule

// ===== test/modbus_rtu_response_receiver_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU reply receiver core.
module modbus_rtu_response_receiver_core_test;
  import mrtu_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PIPE_PAUSE = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_QUOTA = 430;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  mrtu_item_if item_ch();
  mrtu_result_if result_ch();

  modbus_rtu_response_receiver_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item_ch),
    .result(result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies and receiver state of the predictor.
  logic [7:0] slave_cfg;
  logic [6:0] func_cfg;
  logic [3:0] hdr_cfg;
  logic [31:0] tmo_cfg;
  phase_t rx_phase;
  logic [8:0] seen_cnt;
  logic [8:0] frame_target;
  logic [15:0] crc_acc;
  logic [7:0] fn_byte;
  logic [7:0] count_byte;
  logic [31:0] tick_cnt;

  result_t reply_q[$];
  int send_idle_pct;
  int recv_idle_pct;
  int tick_pct;
  bit item_held;
  int items_sent;
  int live_items;
  int replies_checked;
  int mismatches;
  int settings_used;
  int stall_cycles;
  int outcome_cnt[5];

  // Minimum header length applied to the configured value.
  function automatic logic [8:0] header_floor();
    if (hdr_cfg < MIN_HEADER) begin
      return {5'd0, MIN_HEADER};
    end
    return {5'd0, hdr_cfg};
  endfunction

  // Bit-serial form of the reflected CRC-16 update for one byte.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Total reply length implied by the function byte and the byte count.
  function automatic logic [8:0] reply_length(input logic [7:0] fn, input logic [7:0] cnt);
    if (fn inside {FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT,
                   FN_READ_WRITE_REGS}) begin
      return READ_OVERHEAD + {1'b0, cnt};
    end
    if (fn inside {FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS}) begin
      return WRITE_LENGTH;
    end
    if (fn == FN_MASK_WRITE) begin
      return MASK_LENGTH;
    end
    return header_floor();
  endfunction

  // Bytes echoed so far; extra header bytes past a short frame are not counted.
  function automatic logic [8:0] echo_count();
    if (frame_target == 9'd0 || seen_cnt <= frame_target) begin
      return seen_cnt;
    end
    return frame_target;
  endfunction

  // Marks the end of the transaction in a predicted result.
  function automatic result_t wrap_up(input result_t r, input logic [2:0] st,
                                      input logic [7:0] exc, input logic [8:0] len);
    result_t o;
    o = r;
    o.done_res = 1'b1;
    o.status = st;
    o.exception_code = exc;
    o.frame_length = len;
    rx_phase = PH_IDLE;
    outcome_cnt[st]++;
    return o;
  endfunction

  function automatic void reset_model();
    slave_cfg = 8'd1;
    func_cfg = 7'd3;
    hdr_cfg = 4'd5;
    tmo_cfg = 32'd1000;
    rx_phase = PH_IDLE;
    seen_cnt = '0;
    frame_target = '0;
    crc_acc = CRC_INIT;
    fn_byte = '0;
    count_byte = '0;
    tick_cnt = '0;
  endfunction

  function automatic void model_config(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      CFG_SLAVE: begin
        slave_cfg = val[7:0];
      end
      CFG_FUNCTION: begin
        func_cfg = val[6:0];
      end
      CFG_HEADER: begin
        hdr_cfg = val[3:0];
      end
      default: begin
        tmo_cfg = val;
      end
    endcase
  endfunction

  // Predicts the result of one accepted item and queues it if there is one.
  function automatic void model_item(input logic [1:0] m, input logic [7:0] b);
    result_t r;
    logic [8:0] idx;
    r = '0;
    case (m)
      MODE_START: begin
        if (rx_phase == PH_IDLE) begin
          rx_phase = PH_HUNT;
          seen_cnt = '0;
          frame_target = '0;
          crc_acc = CRC_INIT;
          fn_byte = '0;
          count_byte = '0;
          tick_cnt = '0;
          live_items++;
        end
      end
      MODE_TICK: begin
        if (rx_phase != PH_IDLE) begin
          live_items++;
          tick_cnt = tick_cnt + 32'd1;
          if (tick_cnt >= tmo_cfg) begin
            r = wrap_up(r, ST_TIMEOUT, 8'd0, echo_count());
          end
        end
      end
      MODE_BYTE: begin
        if (rx_phase == PH_HUNT) begin
          // The address byte opens the frame; anything else is dropped.
          if (b == slave_cfg) begin
            crc_acc = crc16_step(crc_acc, b);
            seen_cnt = 9'd1;
            rx_phase = PH_HEAD;
            r.frame_byte = b;
            r.byte_valid = 1'b1;
            live_items++;
          end
        end else if (rx_phase != PH_IDLE) begin
          live_items++;
          idx = seen_cnt;
          if (idx < 9'd3 || idx < frame_target) begin
            crc_acc = crc16_step(crc_acc, b);
            r.frame_byte = b;
            r.byte_valid = 1'b1;
            if (idx == 9'd1) begin
              fn_byte = b;
            end
            if (idx == 9'd2) begin
              count_byte = b;
              frame_target = reply_length(fn_byte, b);
            end
          end
          seen_cnt = seen_cnt + 9'd1;
          // Header check: the exception bit goes before the function compare.
          if (rx_phase == PH_HEAD && seen_cnt >= header_floor()) begin
            if (fn_byte[7]) begin
              r = wrap_up(r, ST_EXCEPT, count_byte, echo_count());
            end else if (fn_byte[6:0] != func_cfg) begin
              r = wrap_up(r, ST_BAD_FN, 8'd0, echo_count());
            end else begin
              rx_phase = PH_BODY;
            end
          end
          if (rx_phase == PH_BODY && seen_cnt >= frame_target) begin
            r = wrap_up(r, (crc_acc == 16'd0) ? ST_OK : ST_BAD_CRC, 8'd0, frame_target);
          end
        end
      end
      default: begin
      end
    endcase
    if (r.byte_valid || r.done_res) begin
      reply_q.push_back(r);
    end
  endfunction

  // Sends one item with random idle cycles ahead of it.
  task automatic send_item(input logic [1:0] m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= m;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) begin
      @(posedge clk);
    end
    item_held = 1'b1;
    items_sent++;
    model_item(m, b);
  endtask

  task automatic release_item();
    if (item_held) begin
      item_ch.valid <= 1'b0;
      item_held = 1'b0;
    end
  endtask

  // Waits until every predicted result has come and the pipeline is empty.
  task automatic settle();
    release_item();
    while (reply_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_PAUSE) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    model_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] sl, input logic [6:0] fc,
                               input logic [3:0] hb, input logic [31:0] to);
    settle();
    write_reg(CFG_SLAVE, {24'd0, sl});
    write_reg(CFG_FUNCTION, {25'd0, fc});
    write_reg(CFG_HEADER, {28'd0, hb});
    write_reg(CFG_TIMEOUT, to);
    settings_used++;
  endtask

  // Appends the CRC, low byte first.
  function automatic byte_q_t sealed(input byte_q_t fr);
    byte_q_t o;
    logic [15:0] c;
    o = fr;
    c = CRC_INIT;
    foreach (fr[i]) begin
      c = crc16_step(c, fr[i]);
    end
    o.push_back(c[7:0]);
    o.push_back(c[15:8]);
    return o;
  endfunction

  // Sends frame bytes, with ticks mixed in while a transaction is open.
  task automatic send_seq(input byte_q_t fr);
    foreach (fr[i]) begin
      if (rx_phase != PH_IDLE && $urandom_range(99) < tick_pct) begin
        send_item(MODE_TICK, 8'($urandom));
      end
      send_item(MODE_BYTE, fr[i]);
    end
  endtask

  // Feeds bytes until the open transaction ends, so a start is never lost.
  task automatic close_open();
    while (rx_phase != PH_IDLE) begin
      if (rx_phase == PH_HUNT) begin
        send_item(MODE_BYTE, slave_cfg);
      end else begin
        send_item(MODE_BYTE, 8'($urandom));
      end
    end
  endtask

  function automatic logic [7:0] known_fn(input int k);
    case (k)
      0: return FN_READ_COILS;
      1: return FN_READ_DISCRETE;
      2: return FN_READ_HOLDING;
      3: return FN_READ_INPUT;
      4: return FN_WRITE_COIL;
      5: return FN_WRITE_REG;
      6: return FN_WRITE_COILS;
      7: return FN_WRITE_REGS;
      8: return FN_MASK_WRITE;
      default: return FN_READ_WRITE_REGS;
    endcase
  endfunction

  // Builds a reply with a body that fits the function byte and a valid CRC.
  function automatic byte_q_t build_reply(input logic [7:0] fn);
    byte_q_t fr;
    int cnt;
    fr = {slave_cfg, fn};
    if (fn inside {FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT,
                   FN_READ_WRITE_REGS}) begin
      // Long reads are rare so the run stays short.
      cnt = ($urandom_range(99) < 3) ? $urandom_range(9, 255) : $urandom_range(0, 8);
      fr.push_back(8'(cnt));
      repeat (cnt) begin
        fr.push_back(8'($urandom));
      end
    end else if (fn inside {FN_WRITE_COIL, FN_WRITE_REG, FN_WRITE_COILS, FN_WRITE_REGS}) begin
      repeat (4) begin
        fr.push_back(8'($urandom));
      end
    end else if (fn == FN_MASK_WRITE) begin
      repeat (6) begin
        fr.push_back(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        fr.push_back(8'($urandom));
      end
      if (fn[7] && $urandom_range(3) == 0) begin
        fr[2] = 8'h00;
      end
    end
    return sealed(fr);
  endfunction

  task automatic pick_setting();
    logic [7:0] sl;
    logic [7:0] kf;
    logic [6:0] fc;
    logic [3:0] hb;
    logic [31:0] to;
    int p;
    p = $urandom_range(9);
    sl = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
    p = $urandom_range(9);
    kf = known_fn($urandom_range(9));
    if (p < 7) begin
      fc = kf[6:0];
    end else if (p == 7) begin
      fc = 7'd127;
    end else if (p == 8) begin
      fc = 7'd1;
    end else begin
      fc = 7'($urandom_range(1, 127));
    end
    p = $urandom_range(9);
    hb = (p < 7) ? 4'($urandom_range(3, 8)) : 4'($urandom);
    p = $urandom_range(9);
    if (p < 3) begin
      to = $urandom_range(1, 8);
    end else if (p == 3) begin
      to = 32'd0;
    end else if (p == 4) begin
      to = 32'hFFFF_FFFF;
    end else begin
      to = $urandom_range(20, 2000);
    end
    apply_setting(sl, fc, hb, to);
  endtask

  // One transaction: mostly well-formed replies, some broken ones and noise.
  task automatic run_transaction();
    byte_q_t fr;
    logic [7:0] fn;
    logic [7:0] b;
    int kind;
    int cut;
    int ticks;
    int j;
    send_item(MODE_START, 8'($urandom));
    kind = $urandom_range(99);
    if (kind < 90) begin
      // Line noise that the hunt drops before the address.
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          if (b == slave_cfg) begin
            b = ~b;
          end
          send_item(MODE_BYTE, b);
        end
      end
      if (kind < 60 || kind >= 80) begin
        fn = {1'b0, func_cfg};
      end else if (kind < 70) begin
        fn = $urandom_range(1) ? {1'b1, func_cfg} : (8'($urandom) | 8'h80);
      end else begin
        fn = 8'($urandom);
      end
      fr = build_reply(fn);
      if (kind < 80) begin
        if ($urandom_range(99) < 20) begin
          j = $urandom_range(fr.size() - 1);
          fr[j] = fr[j] ^ 8'($urandom_range(1, 255));
        end
        send_seq(fr);
      end else begin
        // A partial frame followed by ticks toward the timeout.
        cut = $urandom_range(fr.size() - 1);
        for (int i = 0; i < cut; i++) begin
          send_item(MODE_BYTE, fr[i]);
        end
        ticks = 0;
        while (rx_phase != PH_IDLE && ticks < 40) begin
          send_item(MODE_TICK, 8'($urandom));
          ticks++;
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        send_item(2'($urandom), 8'($urandom));
      end
    end
    close_open();
  endtask

  task automatic test_ignored_items();
    // Bytes, ticks and the unused mode change nothing while idle.
    send_item(MODE_BYTE, 8'h01);
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_UNUSED, 8'hFF);
  endtask

  task automatic test_read_reply();
    byte_q_t fr;
    send_item(MODE_START, 8'h00);
    send_item(MODE_START, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_UNUSED, 8'h01);
    fr = {8'h01, FN_READ_HOLDING, 8'h00};
    send_seq(sealed(fr));
  endtask

  task automatic test_exception_code_zero();
    byte_q_t fr;
    settle();
    write_reg(CFG_HEADER, 32'd3);
    send_item(MODE_START, 8'h5A);
    fr = {8'h01, 8'h83, 8'h00};
    send_seq(fr);
  endtask

  task automatic test_bad_function();
    byte_q_t fr;
    send_item(MODE_START, 8'hA5);
    fr = {8'h01, 8'h7F, 8'hFF};
    send_seq(fr);
  endtask

  task automatic test_short_frame_bad_crc();
    byte_q_t fr;
    settle();
    write_reg(CFG_SLAVE, 32'hFF);
    write_reg(CFG_HEADER, 32'd8);
    send_item(MODE_START, 8'h00);
    // A five-byte read under an eight-byte header, with a broken CRC.
    fr = {8'hFF, FN_READ_HOLDING, 8'h00};
    fr = sealed(fr);
    fr[4] = fr[4] ^ 8'h80;
    fr.push_back(8'hAA);
    fr.push_back(8'h55);
    fr.push_back(8'hFF);
    send_seq(fr);
  endtask

  task automatic test_timeout_zero();
    settle();
    write_reg(CFG_TIMEOUT, 32'd0);
    send_item(MODE_START, 8'h00);
    send_item(MODE_TICK, 8'hFF);
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct);
    int mark;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    tick_pct = 4;
    mark = live_items;
    while (live_items - mark < RANDOM_QUOTA) begin
      pick_setting();
      repeat (6) begin
        run_transaction();
      end
    end
  endtask

  // Result side: random back-pressure.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void log_mismatch(input string what, input result_t want,
                                       input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s: expected byte %h valid %b done %b status %0d exc %h len %0d", what,
               want.frame_byte, want.byte_valid, want.done_res, want.status,
               want.exception_code, want.frame_length);
      $display("  actual byte %h valid %b done %b status %0d exc %h len %0d",
               got.frame_byte, got.byte_valid, got.done_res, got.status,
               got.exception_code, got.frame_length);
    end
  endfunction

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.frame_byte = result_ch.frame_byte;
      got.byte_valid = result_ch.byte_valid;
      got.done_res = result_ch.done_res;
      got.status = result_ch.status;
      got.exception_code = result_ch.exception_code;
      got.frame_length = result_ch.frame_length;
      replies_checked++;
      if (reply_q.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = reply_q.pop_front();
        if (got.frame_byte !== want.frame_byte || got.byte_valid !== want.byte_valid ||
            got.done_res !== want.done_res || got.status !== want.status ||
            got.exception_code !== want.exception_code ||
            got.frame_length !== want.frame_length) begin
          log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[modbus_rtu_response_receiver_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SLAVE;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.mode <= MODE_START;
    item_ch.rx_byte <= '0;
    item_held = 1'b0;
    items_sent = 0;
    live_items = 0;
    replies_checked = 0;
    mismatches = 0;
    settings_used = 0;
    stall_cycles = 0;
    foreach (outcome_cnt[i]) begin
      outcome_cnt[i] = 0;
    end
    reset_model();
    send_idle_pct = 17;
    recv_idle_pct = 54;
    tick_pct = 0;
    repeat (5) begin
      @(posedge clk);
    end
    rst <= 1'b0;
    @(posedge clk);

    test_ignored_items();
    test_read_reply();
    test_exception_code_zero();
    test_bad_function();
    test_short_frame_bad_crc();
    test_timeout_zero();
    test_random(17, 54);
    test_random(54, 17);
    test_random(0, 0);
    settle();

    if (reply_q.size() != 0) begin
      $display("%0d expected results never arrived", reply_q.size());
    end
    $display("Sent %0d items (%0d acted on), checked %0d results, %0d register settings.",
             items_sent, live_items, replies_checked, settings_used);
    $display("Endings: %0d ok, %0d bad function, %0d exception, %0d bad crc, %0d timeout.",
             outcome_cnt[ST_OK], outcome_cnt[ST_BAD_FN], outcome_cnt[ST_EXCEPT],
             outcome_cnt[ST_BAD_CRC], outcome_cnt[ST_TIMEOUT]);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("[modbus_rtu_response_receiver_core] OK");
    end else begin
      $display("[modbus_rtu_response_receiver_core] ERROR");
    end
    $finish;
  end

endmodule
